### design/recency_frequency_table_defines.svh
// Assertion macros shared by the recency/frequency table RTL.
// No dependencies; included by the modules that assert.
`ifndef RECENCY_FREQUENCY_TABLE_DEFINES_SVH
`define RECENCY_FREQUENCY_TABLE_DEFINES_SVH

// Same-cycle implication under synchronous active-low reset
`define RFT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under synchronous active-low reset
`define RFT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/rft_pkg.sv
// Shared constants for the recency/frequency table.
// No dependencies.
package rft_pkg;
    localparam int KEY_W  = 64;
    localparam int PORT_W = 16;
    localparam int TIME_W = 63;
    localparam int VAL_W  = 64;

    typedef logic [2:0] t_kind;
    localparam t_kind KIND_HIT     = 3'd0;
    localparam t_kind KIND_NEW     = 3'd1;
    localparam t_kind KIND_EVICT   = 3'd2;
    localparam t_kind KIND_RANKED  = 3'd3;
    localparam t_kind KIND_EMPTY   = 3'd4;

    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_RANK   = 1'b1;
endpackage

### design/recency_frequency_table.sv
// Top level of the recency/frequency table: sequencer, entry RAM, compare.
// Depends on rft_pkg, rft_ram, rft_cmp and recency_frequency_table_defines.svh.
//
//  channel | handshake        | payload
//  --------+------------------+-----------------------------------------------
//  input   | start / busy     | i_opcode i_host_key i_port i_now_ms
//          |                  | i_by_frequency i_max_listed
//  result  | o_valid (strobe) | o_kind o_entry_index o_last o_entry_count
//
// Each entry visit is a RAM read, then a compare, through one read port.
// Record hit at slot m visits slots 0..m; a miss visits all filled slots, then appends;
// a full-table miss adds an oldest scan of all ENTRIES and a shift-down above the oldest.
// Ranking scans all filled slots per listed beat; an empty list beat comes next cycle.
// Reset clears the fill count and the sequencer; entry RAM is not cleared.
// Result beats are strobed for one cycle; the receiver cannot stall them.
`include "recency_frequency_table_defines.svh"

module recency_frequency_table
    import rft_pkg::*;
#(
    parameter int ENTRIES    = 32,
    parameter int COUNT_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_opcode,
    input  logic [63:0]       i_host_key,
    input  logic [15:0]       i_port,
    input  logic [62:0]       i_now_ms,
    input  logic              i_by_frequency,
    input  logic [5:0]        i_max_listed,
    output logic              o_valid,
    output logic [2:0]        o_kind,
    output logic [4:0]        o_entry_index,
    output logic              o_last,
    output logic [5:0]        o_entry_count
);
    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int LW = (CW > 6) ? CW : 6;
    localparam int EW = KEY_W + PORT_W + COUNT_BITS + TIME_W;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_MRD    = 4'd1;
    localparam logic [3:0] S_MCMP   = 4'd2;
    localparam logic [3:0] S_APPEND = 4'd3;
    localparam logic [3:0] S_ORD    = 4'd4;
    localparam logic [3:0] S_OCMP   = 4'd5;
    localparam logic [3:0] S_SHRD   = 4'd6;
    localparam logic [3:0] S_SHWR   = 4'd7;
    localparam logic [3:0] S_RRD    = 4'd8;
    localparam logic [3:0] S_RCMP   = 4'd9;

    // control state
    logic [3:0]         r_state, n_state;
    logic [CW-1:0]      r_fill, n_fill;
    logic               r_busy, n_busy;
    logic               r_valid, n_valid;
    logic [ENTRIES-1:0] r_taken, n_taken;

    // working registers
    logic [IW-1:0]      r_idx, n_idx;
    logic [IW-1:0]      r_bi, n_bi;
    logic [VAL_W-1:0]   r_best, n_best;
    logic               r_first, n_first;
    logic [CW-1:0]      r_cap, n_cap;
    logic [CW-1:0]      r_k, n_k;
    logic [KEY_W-1:0]   r_key, n_key;
    logic [PORT_W-1:0]  r_port, n_port;
    logic [TIME_W-1:0]  r_now, n_now;
    logic               r_byf, n_byf;
    t_kind              r_kind, n_kind;
    t_kind              r_okind, n_okind;
    logic [4:0]         r_oidx, n_oidx;
    logic               r_olast, n_olast;
    logic [5:0]         r_ocnt, n_ocnt;

    // RAM and compare hookup
    logic               we;
    logic [IW-1:0]      waddr, raddr;
    logic [EW-1:0]      wdata, rdata;
    logic [VAL_W-1:0]   cmp_a, cmp_b, val;
    logic               lt;

    logic [KEY_W-1:0]      e_key;
    logic [PORT_W-1:0]     e_port;
    logic [COUNT_BITS-1:0] e_cnt;
    logic [TIME_W-1:0]     e_time;
    logic [LW-1:0]         max_ext, fill_ext;
    logic                  scan_end;
    logic [IW-1:0]         bi_now;
    logic                  rank_last;

    rft_ram #(.WIDTH(EW), .DEPTH(ENTRIES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    rft_cmp u_cmp (
        .i_a  (cmp_a),
        .i_b  (cmp_b),
        .o_lt (lt)
    );

    // unpack the entry word read back
    assign {e_key, e_port, e_cnt, e_time} = rdata;
    assign val      = r_byf ? VAL_W'(e_cnt) : VAL_W'(e_time);
    assign raddr    = (r_state == S_SHRD) ? (r_idx + IW'(1)) : r_idx;
    assign scan_end = (CW'(r_idx) == (r_fill - CW'(1)));
    assign max_ext  = LW'(i_max_listed);
    assign fill_ext = LW'(r_fill);

    // shared compare operands: oldest scan asks time < best, ranking best < value
    always_comb begin
        if (r_state == S_RCMP) begin
            cmp_a = r_best;
            cmp_b = val;
        end else begin
            cmp_a = VAL_W'(e_time);
            cmp_b = r_best;
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;  n_fill  = r_fill;  n_busy  = r_busy;
        n_valid = 1'b0;     n_taken = r_taken; n_idx   = r_idx;
        n_bi    = r_bi;     n_best  = r_best;  n_first = r_first;
        n_cap   = r_cap;    n_k     = r_k;     n_key   = r_key;
        n_port  = r_port;   n_now   = r_now;   n_byf   = r_byf;
        n_kind  = r_kind;   n_okind = r_okind; n_oidx  = r_oidx;
        n_olast = r_olast;  n_ocnt  = r_ocnt;
        we = 1'b0; waddr = r_idx; wdata = rdata;
        bi_now = r_bi; rank_last = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_key = i_host_key; n_port = i_port; n_now = i_now_ms;
                    n_byf = i_by_frequency; n_idx = '0; n_first = 1'b1;
                    n_k = '0; n_taken = '0; n_kind = KIND_NEW;
                    n_cap = (max_ext > fill_ext) ? r_fill : CW'(i_max_listed);
                    if (i_opcode == OP_RECORD) begin
                        n_busy  = 1'b1;
                        n_state = (r_fill == '0) ? S_APPEND : S_MRD;
                    end else if (max_ext == '0 || r_fill == '0) begin
                        n_valid = 1'b1; n_okind = KIND_EMPTY; n_oidx = '0;
                        n_olast = 1'b1; n_ocnt = 6'(r_fill);
                    end else begin
                        n_busy  = 1'b1;
                        n_state = S_RRD;
                    end
                end
            end
            S_MRD:  n_state = S_MCMP;
            S_MCMP: begin
                if (e_key == r_key && e_port == r_port) begin
                    we = 1'b1; waddr = r_idx;
                    wdata = {e_key, e_port,
                             (e_cnt == '1) ? e_cnt : e_cnt + COUNT_BITS'(1), r_now};
                    n_valid = 1'b1; n_okind = KIND_HIT; n_oidx = 5'(r_idx);
                    n_olast = 1'b1; n_ocnt = 6'(r_fill);
                    n_busy = 1'b0; n_state = S_IDLE;
                end else if (scan_end) begin
                    n_idx = '0;
                    n_state = (r_fill == CW'(ENTRIES)) ? S_ORD : S_APPEND;
                end else begin
                    n_idx = r_idx + IW'(1);
                    n_state = S_MRD;
                end
            end
            S_APPEND: begin
                we = 1'b1; waddr = IW'(r_fill);
                wdata = {r_key, r_port, COUNT_BITS'(1), r_now};
                n_fill = r_fill + CW'(1);
                n_valid = 1'b1; n_okind = r_kind; n_oidx = 5'(r_fill);
                n_olast = 1'b1; n_ocnt = 6'(r_fill + CW'(1));
                n_busy = 1'b0; n_state = S_IDLE;
            end
            S_ORD:  n_state = S_OCMP;
            S_OCMP: begin
                // first entry with the strictly smallest time wins
                if (r_idx == '0 || lt) begin
                    n_best = VAL_W'(e_time);
                    bi_now = r_idx;
                end
                n_bi = bi_now;
                if (r_idx == IW'(ENTRIES - 1)) begin
                    n_idx = bi_now;
                    n_kind = KIND_EVICT;
                    if (bi_now == IW'(ENTRIES - 1)) begin
                        n_fill = CW'(ENTRIES - 1);
                        n_state = S_APPEND;
                    end else begin
                        n_state = S_SHRD;
                    end
                end else begin
                    n_idx = r_idx + IW'(1);
                    n_state = S_ORD;
                end
            end
            S_SHRD: n_state = S_SHWR;
            S_SHWR: begin
                // move entry idx+1 down to idx
                we = 1'b1; waddr = r_idx; wdata = rdata;
                if (r_idx + IW'(1) == IW'(ENTRIES - 1)) begin
                    n_fill = CW'(ENTRIES - 1);
                    n_state = S_APPEND;
                end else begin
                    n_idx = r_idx + IW'(1);
                    n_state = S_SHRD;
                end
            end
            S_RRD:  n_state = S_RCMP;
            S_RCMP: begin
                if (!r_taken[r_idx] && (r_first || lt)) begin
                    n_best = val;
                    bi_now = r_idx;
                    n_first = 1'b0;
                end
                n_bi = bi_now;
                if (scan_end) begin
                    rank_last = (r_k + CW'(1) == r_cap);
                    n_taken[bi_now] = 1'b1;
                    n_valid = 1'b1; n_okind = KIND_RANKED; n_oidx = 5'(bi_now);
                    n_olast = rank_last; n_ocnt = 6'(r_fill);
                    n_idx = '0; n_first = 1'b1; n_k = r_k + CW'(1);
                    if (rank_last) begin
                        n_busy = 1'b0; n_state = S_IDLE;
                    end else begin
                        n_state = S_RRD;
                    end
                end else begin
                    n_idx = r_idx + IW'(1);
                    n_state = S_RRD;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_busy  = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
            r_taken <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_busy  <= n_busy;
            r_valid <= n_valid;
            r_taken <= n_taken;
        end
    end

    // payload and scan registers
    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;   r_bi <= n_bi;     r_best <= n_best; r_first <= n_first;
        r_cap <= n_cap;   r_k <= n_k;       r_key <= n_key;   r_port <= n_port;
        r_now <= n_now;   r_byf <= n_byf;   r_kind <= n_kind; r_okind <= n_okind;
        r_oidx <= n_oidx; r_olast <= n_olast; r_ocnt <= n_ocnt;
    end

    assign busy          = r_busy;
    assign o_valid       = r_valid;
    assign o_kind        = r_okind;
    assign o_entry_index = r_oidx;
    assign o_last        = r_olast;
    assign o_entry_count = r_ocnt;

    `RFT_ASSERT_IMP(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= CW'(ENTRIES), "fill overflow")
    `RFT_ASSERT_IMP(a_last_idle, i_clk, i_rst_n, o_valid && o_last, !busy, "busy after last beat")
    `RFT_ASSERT_IMP(a_mid_busy, i_clk, i_rst_n, o_valid && !o_last, busy, "idle mid list")
    `RFT_ASSERT_NXT(a_accept, i_clk, i_rst_n, start && !busy, busy || o_valid, "accept lost")
endmodule

### design/rft_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### design/rft_cmp.sv
// Shared unsigned magnitude compare used by the oldest and ranking scans.
// Depends on rft_pkg.
module rft_cmp
    import rft_pkg::*;
(
    input  logic [VAL_W-1:0] i_a,
    input  logic [VAL_W-1:0] i_b,
    output logic             o_lt
);
    assign o_lt = (i_a < i_b);
endmodule
